// ----- rtl/lacs_pkg.sv -----
// Shared constants, register codes and types of the line-aligned chunk splitter.
package lacs_pkg;

  localparam int OFFSET_BITS    = 40;
  localparam int LINE_BITS      = 32;
  localparam int NUMBER_BITS    = 32;
  localparam int TARGET_BITS    = 27;
  localparam int LOOK_BITS      = 21;
  localparam int MODE_BITS      = 2;
  localparam int CFG_INDEX_BITS = 2;
  localparam int CFG_DATA_BITS  = 27;

  localparam logic [TARGET_BITS-1:0] TARGET_RESET = TARGET_BITS'(1024 * 1024);
  localparam logic [LOOK_BITS-1:0]   LOOK_RESET   = LOOK_BITS'(8192);

  localparam logic [CFG_INDEX_BITS-1:0] CFG_TARGET    = 2'd0;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_LOOKAHEAD = 2'd1;
  localparam logic [CFG_INDEX_BITS-1:0] CFG_MODE      = 2'd2;

  localparam logic [MODE_BITS-1:0] MODE_LF   = 2'd0;
  localparam logic [MODE_BITS-1:0] MODE_CRLF = 2'd1;
  localparam logic [MODE_BITS-1:0] MODE_CR   = 2'd2;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;

  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  typedef struct packed {
    logic [TARGET_BITS-1:0] target;
    logic [LOOK_BITS-1:0]   lookahead;
    logic [MODE_BITS-1:0]   mode;
  } cfg_t;

  typedef struct packed {
    logic complete;
    logic close;
    logic last;
  } token_t;

endpackage

// ----- rtl/lacs_if.sv -----
// Valid/ready channel interfaces for the byte input and the chunk result output.
interface lacs_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       final_byte;

  modport source (output valid, output data_byte, output final_byte, input ready);
  modport sink   (input valid, input data_byte, input final_byte, output ready);
endinterface

interface lacs_out_if;
  logic                             valid;
  logic                             ready;
  logic [lacs_pkg::NUMBER_BITS-1:0] chunk_number;
  logic [lacs_pkg::OFFSET_BITS-1:0] chunk_offset;
  logic [lacs_pkg::OFFSET_BITS-1:0] chunk_length;
  logic [lacs_pkg::LINE_BITS-1:0]   first_line;
  logic [lacs_pkg::LINE_BITS-1:0]   line_total;
  logic                             last_chunk;

  modport source (output valid, output chunk_number, output chunk_offset,
                  output chunk_length, output first_line, output line_total,
                  output last_chunk, input ready);
  modport sink   (input valid, input chunk_number, input chunk_offset,
                  input chunk_length, input first_line, input line_total,
                  input last_chunk, output ready);
endinterface

// ----- rtl/line_aligned_chunk_splitter.sv -----
// Top level of the line-aligned chunk splitter: configuration registers and the three stages.
// The block takes one byte beat per clock cycle without pause as long as results are taken;
// the token of the byte that closes a chunk is written into the queue, and the back end then
// registers its result beat. A waiting result stalls byte intake only once the four-entry
// queue between the front end and the back end has filled. The front end settles the class
// of each byte combinationally from window compares against the target and lookahead, and
// the back end advances the offset and line counters as it takes each token.
module line_aligned_chunk_splitter (
  input  logic                                clk,
  input  logic                                rst_n,
  lacs_in_if.sink                             in_bus,
  lacs_out_if.source                          out_bus,
  input  logic                                cfg_we,
  input  logic [lacs_pkg::CFG_INDEX_BITS-1:0] cfg_index,
  input  logic [lacs_pkg::CFG_DATA_BITS-1:0]  cfg_data
);

  lacs_pkg::cfg_t   cfg_r, cfg_nxt;
  lacs_pkg::token_t front_tok;
  lacs_pkg::token_t back_tok;
  logic             front_valid;
  logic             front_ready;
  logic             back_valid;
  logic             back_ready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        lacs_pkg::CFG_TARGET:    cfg_nxt.target    = cfg_data;
        lacs_pkg::CFG_LOOKAHEAD: cfg_nxt.lookahead = cfg_data[lacs_pkg::LOOK_BITS-1:0];
        lacs_pkg::CFG_MODE:      cfg_nxt.mode      = cfg_data[lacs_pkg::MODE_BITS-1:0];
        default:                 cfg_nxt           = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.target    <= lacs_pkg::TARGET_RESET;
      cfg_r.lookahead <= lacs_pkg::LOOK_RESET;
      cfg_r.mode      <= lacs_pkg::MODE_LF;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  lacs_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_bus    (in_bus),
    .tok       (front_tok),
    .tok_valid (front_valid),
    .tok_ready (front_ready)
  );

  lacs_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_tok   (front_tok),
    .push_valid (front_valid),
    .push_ready (front_ready),
    .pop_tok    (back_tok),
    .pop_valid  (back_valid),
    .pop_ready  (back_ready)
  );

  lacs_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .tok       (back_tok),
    .tok_valid (back_valid),
    .tok_ready (back_ready),
    .out_bus   (out_bus)
  );

endmodule

// ----- rtl/lacs_front.sv -----
// Front end: accepts bytes, tracks the search window and classifies each byte.
module lacs_front (
  input  logic               clk,
  input  logic               rst_n,
  input  lacs_pkg::cfg_t     cfg,
  lacs_in_if.sink            in_bus,
  output lacs_pkg::token_t   tok,
  output logic               tok_valid,
  input  logic               tok_ready
);

  typedef enum logic [2:0] {
    PH_FILL   = 3'b001,
    PH_SEARCH = 3'b010,
    PH_DONE   = 3'b100
  } phase_t;

  logic [lacs_pkg::OFFSET_BITS-1:0] rel_r, rel_nxt;
  phase_t                           phase_r, phase_nxt;
  logic                             pcr_any_r, pcr_any_nxt;
  logic                             pcr_win_r, pcr_win_nxt;

  logic [lacs_pkg::OFFSET_BITS-1:0] target_x;
  logic [lacs_pkg::OFFSET_BITS-1:0] diff;
  logic                             past;
  logic                             in_win;
  logic                             complete;
  logic                             hit;
  logic                             close;
  logic                             beat;

  assign in_bus.ready = tok_ready;
  assign tok_valid    = in_bus.valid;
  assign beat         = in_bus.valid && tok_ready;

  assign target_x = lacs_pkg::OFFSET_BITS'(cfg.target);
  assign past     = rel_r >= target_x;
  assign diff     = rel_r - target_x;
  assign in_win   = (phase_r != PH_DONE) && past &&
                    (diff < lacs_pkg::OFFSET_BITS'(cfg.lookahead));

  always_comb begin
    phase_nxt   = phase_r;
    pcr_any_nxt = pcr_any_r;
    pcr_win_nxt = pcr_win_r;
    complete    = 1'b0;
    hit         = 1'b0;
    if (phase_r != PH_DONE && past) begin
      phase_nxt = in_win ? PH_SEARCH : PH_DONE;
    end
    if (cfg.mode == lacs_pkg::MODE_CRLF) begin
      if (in_bus.data_byte == lacs_pkg::BYTE_LF && pcr_any_r) begin
        complete = 1'b1;
        hit      = pcr_win_r && in_win;
      end
      pcr_any_nxt = (in_bus.data_byte == lacs_pkg::BYTE_CR);
      pcr_win_nxt = (in_bus.data_byte == lacs_pkg::BYTE_CR) && in_win;
    end else if (cfg.mode == lacs_pkg::MODE_CR) begin
      complete = (in_bus.data_byte == lacs_pkg::BYTE_CR);
      hit      = complete && in_win;
    end else begin
      complete = (in_bus.data_byte == lacs_pkg::BYTE_LF);
      hit      = complete && in_win;
    end
    close   = hit || in_bus.final_byte;
    rel_nxt = rel_r + lacs_pkg::OFFSET_BITS'(1);
    if (close) begin
      rel_nxt     = '0;
      phase_nxt   = PH_FILL;
      pcr_any_nxt = 1'b0;
      pcr_win_nxt = 1'b0;
    end
  end

  assign tok.complete = complete;
  assign tok.close    = close;
  assign tok.last     = in_bus.final_byte;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rel_r     <= '0;
      phase_r   <= PH_FILL;
      pcr_any_r <= 1'b0;
      pcr_win_r <= 1'b0;
    end else if (beat) begin
      rel_r     <= rel_nxt;
      phase_r   <= phase_nxt;
      pcr_any_r <= pcr_any_nxt;
      pcr_win_r <= pcr_win_nxt;
    end
  end

endmodule

// ----- rtl/lacs_queue.sv -----
// Short token queue that decouples the front end from the back end.
module lacs_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  lacs_pkg::token_t push_tok,
  input  logic             push_valid,
  output logic             push_ready,
  output lacs_pkg::token_t pop_tok,
  output logic             pop_valid,
  input  logic             pop_ready
);

  lacs_pkg::token_t               mem_r [lacs_pkg::QUEUE_DEPTH];
  logic [lacs_pkg::QUEUE_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [lacs_pkg::QUEUE_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [lacs_pkg::QUEUE_AW:0]    count_r, count_nxt;
  logic                           push;
  logic                           pop;

  assign push_ready = count_r != (lacs_pkg::QUEUE_AW+1)'(lacs_pkg::QUEUE_DEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_tok    = mem_r[rd_ptr_r];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + lacs_pkg::QUEUE_AW'(1) : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + lacs_pkg::QUEUE_AW'(1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + (lacs_pkg::QUEUE_AW+1)'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - (lacs_pkg::QUEUE_AW+1)'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_tok;
    end
  end

endmodule

// ----- rtl/lacs_back.sv -----
// Back end: keeps offsets and line counts and issues one result per closed chunk.
module lacs_back (
  input  logic             clk,
  input  logic             rst_n,
  input  lacs_pkg::token_t tok,
  input  logic             tok_valid,
  output logic             tok_ready,
  lacs_out_if.source       out_bus
);

  logic [lacs_pkg::OFFSET_BITS-1:0] begin_r, begin_nxt;
  logic [lacs_pkg::OFFSET_BITS-1:0] len_r, len_nxt;
  logic [lacs_pkg::NUMBER_BITS-1:0] counter_r, counter_nxt;
  logic [lacs_pkg::LINE_BITS-1:0]   line_r, line_nxt;
  logic [lacs_pkg::LINE_BITS-1:0]   lines_r, lines_nxt;
  logic                             ov_r, ov_nxt;

  logic [lacs_pkg::OFFSET_BITS-1:0] length;
  logic [lacs_pkg::LINE_BITS-1:0]   total;
  logic                             take;
  logic                             emit;

  assign tok_ready = !tok.close || !ov_r || out_bus.ready;
  assign take      = tok_valid && tok_ready;
  assign emit      = take && tok.close;
  assign length    = len_r + lacs_pkg::OFFSET_BITS'(1);
  assign total     = lines_r + lacs_pkg::LINE_BITS'(1);

  always_comb begin
    begin_nxt   = begin_r;
    len_nxt     = len_r;
    counter_nxt = counter_r;
    line_nxt    = line_r;
    lines_nxt   = lines_r;
    ov_nxt      = ov_r && !out_bus.ready;
    if (take) begin
      if (!tok.close) begin
        len_nxt   = length;
        lines_nxt = tok.complete ? total : lines_r;
      end else if (tok.last) begin
        begin_nxt   = '0;
        len_nxt     = '0;
        counter_nxt = '0;
        line_nxt    = lacs_pkg::LINE_BITS'(1);
        lines_nxt   = '0;
      end else begin
        begin_nxt   = begin_r + length;
        len_nxt     = '0;
        counter_nxt = counter_r + lacs_pkg::NUMBER_BITS'(1);
        line_nxt    = line_r + total;
        lines_nxt   = '0;
      end
    end
    if (emit) begin
      ov_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      begin_r   <= '0;
      len_r     <= '0;
      counter_r <= '0;
      line_r    <= lacs_pkg::LINE_BITS'(1);
      lines_r   <= '0;
      ov_r      <= 1'b0;
    end else begin
      begin_r   <= begin_nxt;
      len_r     <= len_nxt;
      counter_r <= counter_nxt;
      line_r    <= line_nxt;
      lines_r   <= lines_nxt;
      ov_r      <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_bus.chunk_number <= counter_r;
      out_bus.chunk_offset <= begin_r;
      out_bus.chunk_length <= length;
      out_bus.first_line   <= line_r;
      out_bus.line_total   <= total;
      out_bus.last_chunk   <= tok.last;
    end
  end

  assign out_bus.valid = ov_r;

endmodule

// ----- rtl/lacs_checker.sv -----
// Port-level assertions for the chunk splitter, bound to its top level.
module lacs_checker (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             out_valid,
  input logic                             out_ready,
  input logic [lacs_pkg::NUMBER_BITS-1:0] out_chunk_number,
  input logic [lacs_pkg::OFFSET_BITS-1:0] out_chunk_offset,
  input logic [lacs_pkg::OFFSET_BITS-1:0] out_chunk_length,
  input logic [lacs_pkg::LINE_BITS-1:0]   out_first_line
);

  // A result beat that has not been taken stays offered.
  a_valid_holds : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result beat withdrawn before it was taken");

  // A stalled result beat keeps its number, offset, length and first line.
  a_payload_holds : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> $stable(out_chunk_offset) && $stable(out_chunk_length)
                                && $stable(out_chunk_number) && $stable(out_first_line))
    else $error("stalled result beat changed its payload");

  // Reset leaves no result pending.
  a_reset_clears : assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result offered straight after reset");

  // The first chunk of a stream starts at offset zero on line one.
  a_first_chunk : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_chunk_number == '0 |->
      out_chunk_offset == '0 && out_first_line == lacs_pkg::LINE_BITS'(1))
    else $error("first chunk of a stream does not start at its beginning");

endmodule

bind line_aligned_chunk_splitter lacs_checker u_lacs_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_bus.valid),
  .out_ready        (out_bus.ready),
  .out_chunk_number (out_bus.chunk_number),
  .out_chunk_offset (out_bus.chunk_offset),
  .out_chunk_length (out_bus.chunk_length),
  .out_first_line   (out_bus.first_line)
);

// ----- tb/sv/tb_line_aligned_chunk_splitter.sv -----
// Self-checking bench for the chunk splitter: directed rows, then random streams scored by a predictor.
module tb_line_aligned_chunk_splitter;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int RANDOM_BYTES   = 1800;
  localparam int CALM_FROM      = 1500;
  localparam int SETTLE_CYCLES  = 12;
  localparam int DRAIN_CYCLES   = 20;
  localparam int WATCHDOG_LIMIT = 2000;

  localparam logic [lacs_pkg::CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;

  localparam logic [1:0] SCAN_FILL = 2'd0;
  localparam logic [1:0] SCAN_SEEK = 2'd1;
  localparam logic [1:0] SCAN_DONE = 2'd2;

  localparam logic [1:0] CR_NONE    = 2'd0;
  localparam logic [1:0] CR_OUTSIDE = 2'd1;
  localparam logic [1:0] CR_INSIDE  = 2'd2;

  typedef struct packed {
    logic [lacs_pkg::NUMBER_BITS-1:0] chunk_number;
    logic [lacs_pkg::OFFSET_BITS-1:0] chunk_offset;
    logic [lacs_pkg::OFFSET_BITS-1:0] chunk_length;
    logic [lacs_pkg::LINE_BITS-1:0]   first_line;
    logic [lacs_pkg::LINE_BITS-1:0]   line_total;
    logic                             last_chunk;
  } chunk_rec_t;

  typedef enum logic {ROW_BYTE, ROW_CFG} row_kind_t;

  typedef struct packed {
    row_kind_t                           kind;
    logic [lacs_pkg::CFG_INDEX_BITS-1:0] index;
    logic [lacs_pkg::CFG_DATA_BITS-1:0]  value;
    logic [7:0]                          data_byte;
    logic                                final_byte;
    logic                                typed;
    chunk_rec_t                          want;
  } plan_row_t;

  localparam chunk_rec_t NO_REC = '0;

  localparam int PLAN_ROWS = 28;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h41, 1'b1, 1'b1, '{0, 0, 1, 1, 1, 1}},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h0A, 1'b1, 1'b1, '{0, 0, 1, 1, 1, 1}},
    '{ROW_CFG,  lacs_pkg::CFG_TARGET,    27'd0,       8'h00, 1'b0, 1'b0, NO_REC},
    '{ROW_CFG,  lacs_pkg::CFG_LOOKAHEAD, 27'd0,       8'h00, 1'b0, 1'b0, NO_REC},
    '{ROW_CFG,  CFG_UNUSED,              27'h7FFFFFF, 8'h00, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h0A, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h0A, 1'b1, 1'b1, '{0, 0, 2, 1, 2, 1}},
    '{ROW_CFG,  lacs_pkg::CFG_LOOKAHEAD, 27'd1,       8'h00, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h0A, 1'b0, 1'b1, '{0, 0, 1, 1, 1, 0}},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h78, 1'b1, 1'b1, '{1, 1, 1, 2, 1, 1}},
    '{ROW_CFG,  lacs_pkg::CFG_MODE,      27'd3,       8'h00, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h0A, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'hFF, 1'b1, 1'b0, NO_REC},
    '{ROW_CFG,  lacs_pkg::CFG_TARGET,    27'd2,       8'h00, 1'b0, 1'b0, NO_REC},
    '{ROW_CFG,  lacs_pkg::CFG_LOOKAHEAD, 27'd2,       8'h00, 1'b0, 1'b0, NO_REC},
    '{ROW_CFG,  lacs_pkg::CFG_MODE, 27'(lacs_pkg::MODE_CRLF), 8'h00, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h61, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h0D, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h0A, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h0D, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h0A, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h62, 1'b1, 1'b0, NO_REC},
    '{ROW_CFG,  lacs_pkg::CFG_TARGET,    27'h7FFFFFF, 8'h00, 1'b0, 1'b0, NO_REC},
    '{ROW_CFG,  lacs_pkg::CFG_LOOKAHEAD, 27'h1FFFFF,  8'h00, 1'b0, 1'b0, NO_REC},
    '{ROW_CFG,  lacs_pkg::CFG_MODE, 27'(lacs_pkg::MODE_CR), 8'h00, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h00, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'h0D, 1'b0, 1'b0, NO_REC},
    '{ROW_BYTE, lacs_pkg::CFG_TARGET,    27'd0,       8'hFF, 1'b1, 1'b1, '{0, 0, 3, 1, 2, 1}}
  };

  logic                                clk;
  logic                                rst_n;
  logic                                cfg_we;
  logic [lacs_pkg::CFG_INDEX_BITS-1:0] cfg_index;
  logic [lacs_pkg::CFG_DATA_BITS-1:0]  cfg_data;

  lacs_in_if  in_bus ();
  lacs_out_if out_bus ();

  line_aligned_chunk_splitter uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_bus   (in_bus),
    .out_bus  (out_bus),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  logic [lacs_pkg::TARGET_BITS-1:0] tgt_len;
  logic [lacs_pkg::LOOK_BITS-1:0]   look_len;
  logic [lacs_pkg::MODE_BITS-1:0]   eol_mode;
  logic [lacs_pkg::OFFSET_BITS-1:0] pos_now;
  logic [lacs_pkg::OFFSET_BITS-1:0] chunk_start;
  logic [lacs_pkg::NUMBER_BITS-1:0] chunk_idx;
  logic [lacs_pkg::LINE_BITS-1:0]   line_next;
  logic [lacs_pkg::LINE_BITS-1:0]   lines_seen;
  logic [1:0]                       cr_seen;
  logic [1:0]                       scan_phase;
  logic                             ended_eol;

  chunk_rec_t chunks_due[$];
  bit         idle_on;
  int         err_count;
  int         byte_count;
  int         quiet_cycles;

  always #10 clk = ~clk;

  function automatic void restart_stream();
    pos_now     = '0;
    chunk_start = '0;
    chunk_idx   = '0;
    line_next   = 1;
    lines_seen  = '0;
    cr_seen     = CR_NONE;
    scan_phase  = SCAN_FILL;
    ended_eol   = 1'b0;
  endfunction

  function automatic bit split_byte(input logic [7:0] b, input logic fin,
                                    output chunk_rec_t rec);
    logic [lacs_pkg::OFFSET_BITS-1:0] rel;
    logic [lacs_pkg::OFFSET_BITS-1:0] tgt_wide;
    logic [lacs_pkg::OFFSET_BITS-1:0] look_wide;
    logic [lacs_pkg::LINE_BITS-1:0]   total;
    logic                             in_win;
    logic                             eol;
    logic                             boundary;
    rel       = pos_now - chunk_start;
    tgt_wide  = tgt_len;
    look_wide = look_len;
    in_win    = 1'b0;
    eol       = 1'b0;
    boundary  = 1'b0;
    rec       = NO_REC;
    if (scan_phase != SCAN_DONE && rel >= tgt_wide) begin
      if (rel - tgt_wide < look_wide) begin
        in_win     = 1'b1;
        scan_phase = SCAN_SEEK;
      end else begin
        scan_phase = SCAN_DONE;
      end
    end
    if (eol_mode == lacs_pkg::MODE_CRLF) begin
      if (b == lacs_pkg::BYTE_LF && cr_seen != CR_NONE) begin
        eol      = 1'b1;
        boundary = (cr_seen == CR_INSIDE) && in_win;
      end
      cr_seen = (b == lacs_pkg::BYTE_CR) ? (in_win ? CR_INSIDE : CR_OUTSIDE) : CR_NONE;
    end else if (b == ((eol_mode == lacs_pkg::MODE_CR) ? lacs_pkg::BYTE_CR
                                                       : lacs_pkg::BYTE_LF)) begin
      eol      = 1'b1;
      boundary = in_win;
    end
    if (eol) lines_seen = lines_seen + 1'b1;
    ended_eol = eol;
    if (!(boundary || fin)) begin
      pos_now = pos_now + 1'b1;
      return 1'b0;
    end
    total = lines_seen + (ended_eol ? 0 : 1);
    rec = '{chunk_idx, chunk_start, rel + 40'd1, line_next, total, fin};
    if (fin) begin
      restart_stream();
    end else begin
      pos_now     = pos_now + 1'b1;
      chunk_start = pos_now;
      chunk_idx   = chunk_idx + 1'b1;
      line_next   = line_next + total;
      lines_seen  = '0;
      cr_seen     = CR_NONE;
      scan_phase  = SCAN_FILL;
      ended_eol   = 1'b0;
    end
    return 1'b1;
  endfunction

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  task automatic check_field(input string name, input logic [63:0] got, input logic [63:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %0d, expected %0d", name, got, want));
  endtask

  task automatic settle();
    in_bus.valid <= 1'b0;
    while (chunks_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [lacs_pkg::CFG_INDEX_BITS-1:0] idx,
                           input logic [lacs_pkg::CFG_DATA_BITS-1:0]  val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    case (idx)
      lacs_pkg::CFG_TARGET:    tgt_len  = val[lacs_pkg::TARGET_BITS-1:0];
      lacs_pkg::CFG_LOOKAHEAD: look_len = val[lacs_pkg::LOOK_BITS-1:0];
      lacs_pkg::CFG_MODE:      eol_mode = val[lacs_pkg::MODE_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic send_byte(input logic [7:0] b, input logic fin, input logic typed,
                           input chunk_rec_t want);
    chunk_rec_t rec;
    if (cfg_we) cfg_we <= 1'b0;
    if (idle_on && $urandom_range(0, 7) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
    in_bus.valid      <= 1'b1;
    in_bus.data_byte  <= b;
    in_bus.final_byte <= fin;
    do @(posedge clk); while (in_bus.ready !== 1'b1);
    if (split_byte(b, fin, rec)) chunks_due.push_back(typed ? want : rec);
    byte_count++;
  endtask

  // Mostly text lines in the active ending style; now and then a stream of raw noise.
  task automatic send_stream(input logic [lacs_pkg::MODE_BITS-1:0] m, input int len);
    int         n;
    bit         noisy;
    logic [7:0] b;
    noisy = ($urandom_range(0, 7) == 0);
    n = 0;
    while (n < len) begin
      if (noisy) begin
        case ($urandom_range(0, 3))
          0:       b = lacs_pkg::BYTE_LF;
          1:       b = lacs_pkg::BYTE_CR;
          default: b = 8'($urandom_range(0, 255));
        endcase
      end else if ($urandom_range(0, 7) == 0) begin
        if (m == lacs_pkg::MODE_CRLF && n < len - 1) begin
          send_byte(lacs_pkg::BYTE_CR, 1'b0, 1'b0, NO_REC);
          n++;
        end
        b = (m == lacs_pkg::MODE_CR) ? lacs_pkg::BYTE_CR : lacs_pkg::BYTE_LF;
      end else begin
        b = 8'($urandom_range(8'h20, 8'h7E));
      end
      send_byte(b, n == len - 1, 1'b0, NO_REC);
      n++;
    end
  endtask

  initial begin
    int stall;
    chunk_rec_t want;
    stall = 0;
    out_bus.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) begin
        if (chunks_due.size() == 0) begin
          report_mismatch("result beat with no chunk expected");
        end else begin
          want = chunks_due.pop_front();
          check_field("chunk_number", out_bus.chunk_number, want.chunk_number);
          check_field("chunk_offset", out_bus.chunk_offset, want.chunk_offset);
          check_field("chunk_length", out_bus.chunk_length, want.chunk_length);
          check_field("first_line", out_bus.first_line, want.first_line);
          check_field("line_total", out_bus.line_total, want.line_total);
          check_field("last_chunk", out_bus.last_chunk, want.last_chunk);
        end
      end
      if (!rst_n) begin
        out_bus.ready <= 1'b0;
      end else if (stall > 0) begin
        stall--;
        out_bus.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 9) == 0) begin
        stall = $urandom_range(1, 18) - 1;
        out_bus.ready <= 1'b0;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid === 1'b1 && in_bus.ready === 1'b1) ||
        (out_bus.valid === 1'b1 && out_bus.ready === 1'b1) || cfg_we === 1'b1) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    int                               rand_start;
    bit                               prev_cfg;
    bit                               big;
    logic [lacs_pkg::TARGET_BITS-1:0] t_val;
    logic [lacs_pkg::LOOK_BITS-1:0]   l_val;
    logic [lacs_pkg::MODE_BITS-1:0]   m_val;

    clk               = 1'b0;
    rst_n             = 1'b0;
    cfg_we            = 1'b0;
    cfg_index         = '0;
    cfg_data          = '0;
    in_bus.valid      = 1'b0;
    in_bus.data_byte  = '0;
    in_bus.final_byte = 1'b0;
    idle_on           = 1'b1;
    err_count         = 0;
    byte_count        = 0;
    quiet_cycles      = 0;
    tgt_len           = lacs_pkg::TARGET_RESET;
    look_len          = lacs_pkg::LOOK_RESET;
    eol_mode          = lacs_pkg::MODE_LF;
    restart_stream();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    prev_cfg = 1'b0;
    for (int i = 0; i < PLAN_ROWS; i++) begin
      if (PLAN[i].kind == ROW_CFG) begin
        if (!prev_cfg) settle();
        cfg_write(PLAN[i].index, PLAN[i].value);
        prev_cfg = 1'b1;
      end else begin
        send_byte(PLAN[i].data_byte, PLAN[i].final_byte, PLAN[i].typed, PLAN[i].want);
        prev_cfg = 1'b0;
      end
    end

    // Large targets and windows get short streams, so their chunks close on the final byte.
    rand_start = byte_count;
    while (byte_count - rand_start < RANDOM_BYTES) begin
      big = ($urandom_range(0, 9) == 0);
      if (big) begin
        case ($urandom_range(0, 3))
          0:       t_val = 27'd65536;
          1:       t_val = lacs_pkg::TARGET_RESET;
          2:       t_val = 27'd104857600;
          default: t_val = 27'h7FFFFFF;
        endcase
        case ($urandom_range(0, 3))
          0:       l_val = 21'd1;
          1:       l_val = lacs_pkg::LOOK_RESET;
          2:       l_val = 21'd1048576;
          default: l_val = 21'h1FFFFF;
        endcase
      end else begin
        t_val = ($urandom_range(0, 5) == 0) ? 27'd0 : 27'($urandom_range(1, 48));
        l_val = ($urandom_range(0, 7) == 0) ? 21'($urandom_range(0, 21'h1FFFFF))
                                             : 21'($urandom_range(0, 24));
      end
      m_val = 2'($urandom_range(0, 3));
      idle_on = (byte_count - rand_start < CALM_FROM) && ($urandom_range(0, 3) != 0);
      settle();
      cfg_write(lacs_pkg::CFG_TARGET, t_val);
      cfg_write(lacs_pkg::CFG_LOOKAHEAD, 27'(l_val));
      cfg_write(lacs_pkg::CFG_MODE, 27'(m_val));
      repeat ($urandom_range(1, 4)) send_stream(m_val, big ? $urandom_range(1, 40)
                                                           : $urandom_range(1, 80));
    end

    in_bus.valid <= 1'b0;
    while (chunks_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ----- line_aligned_chunk_splitter.f -----
rtl/lacs_pkg.sv
rtl/lacs_if.sv
rtl/lacs_front.sv
rtl/lacs_queue.sv
rtl/lacs_back.sv
rtl/line_aligned_chunk_splitter.sv
rtl/lacs_checker.sv
tb/sv/tb_line_aligned_chunk_splitter.sv
